// ===== rtl/tpru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpru_pkg: shared types and constants of the trapezoid phase response block
// Fixed-point widths, word types of both channels, the configuration set and
// the sideband that rides along with an item through the divider.
// ----------------------------------------------------------------------------
package tpru_pkg;

  // Time and phase format
  localparam int unsigned TimeBits = 48;
  localparam int unsigned FracBits = 16;

  // Derived widths
  localparam int unsigned PointW  = FracBits + 1;      // unsigned Q1.F point
  localparam int unsigned HeightW = FracBits + 2;      // signed Q1.F height
  localparam int unsigned PhaseW  = FracBits + 1;      // phase in [0, 2)
  localparam int unsigned ProdW   = 2 * HeightW;       // signed product
  localparam int unsigned NumW    = 2 * FracBits + 3;  // numerator magnitude
  localparam int unsigned DenW    = PointW;            // segment length
  localparam int unsigned QuoW    = FracBits + 2;      // quotient magnitude
  localparam int unsigned ShiftW  = FracBits + 3;      // signed phase shift
  localparam int unsigned NewPhW  = FracBits + 4;      // signed shifted phase

  // Fixed-point one
  localparam logic [TimeBits-1:0] OneTime  = {{(TimeBits-1){1'b0}}, 1'b1} << FracBits;
  localparam logic [PhaseW-1:0]   OnePhase = {1'b1, {FracBits{1'b0}}};

  // Register reset values
  localparam logic [PointW-1:0]  PointAReset = '0;
  localparam logic [PointW-1:0]  PointBReset = PointW'(1 << (FracBits - 2));
  localparam logic [PointW-1:0]  PointCReset = PointW'(3 << (FracBits - 2));
  localparam logic [PointW-1:0]  PointDReset = PointW'(1 << FracBits);
  localparam logic [HeightW-1:0] HeightReset = '0;

  // Register bus
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  typedef enum logic [2:0] {
    RegPointA    = 3'd0,
    RegPointB    = 3'd1,
    RegPointC    = 3'd2,
    RegPointD    = 3'd3,
    RegHeightOne = 3'd4,
    RegHeightTwo = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    ActNone    = 2'd0,
    ActEarlier = 2'd1,
    ActLater   = 2'd2
  } action_e;

  typedef struct packed {
    logic [TimeBits-1:0] now_time;
    logic [TimeBits-1:0] scheduled_fire_time;
    logic                coupling_positive;
  } in_word_t;

  typedef struct packed {
    logic [TimeBits-1:0] new_fire_time;
    action_e             action;
  } out_word_t;

  typedef struct packed {
    logic [PointW-1:0]  point_a;
    logic [PointW-1:0]  point_b;
    logic [PointW-1:0]  point_c;
    logic [PointW-1:0]  point_d;
    logic [HeightW-1:0] height_one;
    logic [HeightW-1:0] height_two;
  } cfg_t;

  // Carried alongside the division
  typedef struct packed {
    logic [PhaseW-1:0]   phase;
    logic [TimeBits-1:0] now_time;
    logic [TimeBits-1:0] fire_time;
    logic                positive;
    logic                hit;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/tpru_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpru_div: pipelined unsigned restoring divider
// One quotient bit per stage, QuoW stages. The caller guarantees the quotient
// fits in QuoW bits. A sideband word travels with each item.
// ----------------------------------------------------------------------------
module tpru_div #(
  parameter int unsigned NumW  = 35,
  parameter int unsigned DenW  = 17,
  parameter int unsigned QuoW  = 18,
  parameter int unsigned SideW = 116
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic             neg_i,
  input  logic [SideW-1:0] side_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [QuoW-1:0]  quo_o,
  output logic             neg_o,
  output logic [SideW-1:0] side_o
);

  logic [QuoW-1:0]  valid_q, valid_d;
  logic [QuoW-1:0]  en;

  logic [DenW-1:0]  rem_q  [QuoW];
  logic [QuoW-1:0]  lo_q   [QuoW];
  logic [DenW-1:0]  den_q  [QuoW];
  logic             neg_q  [QuoW];
  logic [SideW-1:0] side_q [QuoW];

  logic [DenW-1:0]  rem_d  [QuoW];
  logic [QuoW-1:0]  lo_d   [QuoW];
  logic [DenW-1:0]  den_d  [QuoW];
  logic             neg_d  [QuoW];
  logic [SideW-1:0] side_d [QuoW];

  // A stage may load when the output drains or a bubble sits at or after it
  genvar k;
  generate
    for (k = 0; k < QuoW; k++) begin : g_en
      assign en[k] = !out_stall_i || !(&valid_q[QuoW-1:k]);
    end
  endgenerate

  assign in_stall_o = !en[0];

  // Valid bits advance with their stage
  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < QuoW; i++) begin
      valid_d[i] = en[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // One restoring step per stage
  always_comb begin
    logic [DenW-1:0]  src_rem;
    logic [QuoW-1:0]  src_lo;
    logic [DenW:0]    trial;
    logic             fits;
    for (int i = 0; i < QuoW; i++) begin
      if (i == 0) begin
        src_rem   = DenW'(num_i[NumW-1:QuoW]);
        src_lo    = num_i[QuoW-1:0];
        den_d[i]  = den_i;
        neg_d[i]  = neg_i;
        side_d[i] = side_i;
      end else begin
        src_rem   = rem_q[i-1];
        src_lo    = lo_q[i-1];
        den_d[i]  = den_q[i-1];
        neg_d[i]  = neg_q[i-1];
        side_d[i] = side_q[i-1];
      end
      trial    = {src_rem, src_lo[QuoW-1]};
      fits     = trial >= {1'b0, den_d[i]};
      rem_d[i] = fits ? DenW'(trial - {1'b0, den_d[i]}) : trial[DenW-1:0];
      lo_d[i]  = {src_lo[QuoW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QuoW; i++) begin
      if (en[i]) begin
        rem_q[i]  <= rem_d[i];
        lo_q[i]   <= lo_d[i];
        den_q[i]  <= den_d[i];
        neg_q[i]  <= neg_d[i];
        side_q[i] <= side_d[i];
      end
    end
  end

  assign out_valid_o = valid_q[QuoW-1];
  assign quo_o       = lo_q[QuoW-1];
  assign neg_o       = neg_q[QuoW-1];
  assign side_o      = side_q[QuoW-1];

endmodule
`default_nettype wire

// ===== rtl/tpru_numer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpru_numer: phase, segment selection and numerator of the response
// Five stages: time difference, phase and window, segment factors,
// products, then sum split into sign and magnitude for the divider.
// ----------------------------------------------------------------------------
module tpru_numer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tpru_pkg::in_word_t          in_word_i,
  input  tpru_pkg::cfg_t              cfg_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tpru_pkg::NumW-1:0]   num_o,
  output logic [tpru_pkg::DenW-1:0]   den_o,
  output logic                        neg_o,
  output tpru_pkg::side_t             side_o
);
  import tpru_pkg::*;

  localparam int unsigned NumStages = 5;

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] en;

  // Stage 1: time difference
  logic [TimeBits-1:0] s1_now_q, s1_fire_q, s1_mag_q, s1_mag_d;
  logic                s1_pos_q, s1_ge_q, s1_ge_d;
  // Stage 2: phase and window
  logic [PhaseW-1:0]   s2_phase_q, s2_phase_d;
  logic                s2_hit_q, s2_hit_d;
  logic [TimeBits-1:0] s2_now_q, s2_fire_q;
  logic                s2_pos_q;
  // Stage 3: segment factors
  logic [PointW-1:0]   s3_x1_q, s3_x1_d, s3_x2_q, s3_x2_d;
  logic [DenW-1:0]     s3_den_q, s3_den_d;
  side_t               s3_side_q, s3_side_d;
  // Stage 4: products
  logic [ProdW-1:0]    s4_p1_q, s4_p1_d, s4_p2_q, s4_p2_d;
  logic [DenW-1:0]     s4_den_q;
  side_t               s4_side_q;
  // Stage 5: sign and magnitude
  logic [ProdW:0]      s5_sum_w, s5_mag_w;
  logic [NumW-1:0]     s5_num_q;
  logic                s5_neg_q;
  logic [DenW-1:0]     s5_den_q;
  side_t               s5_side_q;

  // A stage may load when the output drains or a bubble sits at or after it
  genvar k;
  generate
    for (k = 0; k < NumStages; k++) begin : g_en
      assign en[k] = !out_stall_i || !(&valid_q[NumStages-1:k]);
    end
  endgenerate

  assign in_stall_o = !en[0];

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < NumStages; i++) begin
      valid_d[i] = en[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Take the distance between now and the firing time
  always_comb begin
    s1_ge_d  = in_word_i.now_time >= in_word_i.scheduled_fire_time;
    s1_mag_d = s1_ge_d ? in_word_i.now_time - in_word_i.scheduled_fire_time
                       : in_word_i.scheduled_fire_time - in_word_i.now_time;
  end

  // Form phase = 1 + now - fire and mark items outside [0, 2) as misses
  always_comb begin
    if (s1_ge_q) begin
      s2_hit_d   = (s1_mag_q[TimeBits-1:FracBits] == '0);
      s2_phase_d = {1'b1, s1_mag_q[FracBits-1:0]};
    end else begin
      s2_hit_d   = (s1_mag_q <= OneTime);
      s2_phase_d = OnePhase - s1_mag_q[PhaseW-1:0];
    end
  end

  // Pick the segment: shift numerator is x1 * h1 + x2 * h2
  always_comb begin
    s3_side_d.phase     = s2_phase_q;
    s3_side_d.now_time  = s2_now_q;
    s3_side_d.fire_time = s2_fire_q;
    s3_side_d.positive  = s2_pos_q;
    s3_side_d.hit       = s2_hit_q;
    s3_x1_d             = '0;
    s3_x2_d             = '0;
    s3_den_d            = DenW'(1);
    priority if (s2_phase_q < cfg_i.point_a) begin
      s3_side_d.hit = 1'b0;
    end else if (s2_phase_q < cfg_i.point_b) begin
      s3_x1_d  = s2_phase_q - cfg_i.point_a;
      s3_den_d = cfg_i.point_b - cfg_i.point_a;
    end else if (s2_phase_q < cfg_i.point_c) begin
      s3_x1_d  = cfg_i.point_c - s2_phase_q;
      s3_x2_d  = s2_phase_q - cfg_i.point_b;
      s3_den_d = cfg_i.point_c - cfg_i.point_b;
    end else if (s2_phase_q < cfg_i.point_d) begin
      s3_x2_d  = cfg_i.point_d - s2_phase_q;
      s3_den_d = cfg_i.point_d - cfg_i.point_c;
    end else begin
      s3_side_d.hit = 1'b0;
    end
  end

  // Multiply each factor by its height
  always_comb begin
    s4_p1_d = $signed({1'b0, s3_x1_q}) * $signed(cfg_i.height_one);
    s4_p2_d = $signed({1'b0, s3_x2_q}) * $signed(cfg_i.height_two);
  end

  // Add the products and split into sign and magnitude
  always_comb begin
    s5_sum_w = {s4_p1_q[ProdW-1], s4_p1_q} + {s4_p2_q[ProdW-1], s4_p2_q};
    s5_mag_w = s5_sum_w[ProdW] ? (~s5_sum_w + 1'b1) : s5_sum_w;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_now_q  <= in_word_i.now_time;
      s1_fire_q <= in_word_i.scheduled_fire_time;
      s1_pos_q  <= in_word_i.coupling_positive;
      s1_ge_q   <= s1_ge_d;
      s1_mag_q  <= s1_mag_d;
    end
    if (en[1]) begin
      s2_phase_q <= s2_phase_d;
      s2_hit_q   <= s2_hit_d;
      s2_now_q   <= s1_now_q;
      s2_fire_q  <= s1_fire_q;
      s2_pos_q   <= s1_pos_q;
    end
    if (en[2]) begin
      s3_x1_q   <= s3_x1_d;
      s3_x2_q   <= s3_x2_d;
      s3_den_q  <= s3_den_d;
      s3_side_q <= s3_side_d;
    end
    if (en[3]) begin
      s4_p1_q   <= s4_p1_d;
      s4_p2_q   <= s4_p2_d;
      s4_den_q  <= s3_den_q;
      s4_side_q <= s3_side_q;
    end
    if (en[4]) begin
      s5_num_q  <= s5_mag_w[NumW-1:0];
      s5_neg_q  <= s5_sum_w[ProdW];
      s5_den_q  <= s4_den_q;
      s5_side_q <= s4_side_q;
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign num_o       = s5_num_q;
  assign den_o       = s5_den_q;
  assign neg_o       = s5_neg_q;
  assign side_o      = s5_side_q;

endmodule
`default_nettype wire

// ===== rtl/tpru_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpru_update: apply the shift, clamp the phase and reschedule
// Two stages: signed shift and clamp, then the new firing time into the
// output register.
// ----------------------------------------------------------------------------
module tpru_update (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [tpru_pkg::QuoW-1:0] quo_i,
  input  logic                      neg_i,
  input  tpru_pkg::side_t           side_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tpru_pkg::out_word_t       out_word_o
);
  import tpru_pkg::*;

  localparam int unsigned NumStages = 2;
  localparam logic signed [NewPhW-1:0] NpOne = {{(NewPhW-PhaseW){1'b0}}, OnePhase};

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] en;

  logic [ShiftW-1:0]          u1_quo_w, u1_shift_w;
  logic signed [NewPhW-1:0]   u1_sum_w;
  logic signed [NewPhW-1:0]   u1_np_q, u1_np_d;
  action_e                    u1_act_q, u1_act_d;
  logic [TimeBits-1:0]        u1_nowp_q, u1_fire_q;

  logic [TimeBits-1:0]        u2_npx_w, u2_time_w;
  out_word_t                  out_word_q, out_word_d;

  // A stage may load when the output drains or a bubble sits at or after it
  genvar k;
  generate
    for (k = 0; k < NumStages; k++) begin : g_en
      assign en[k] = !out_stall_i || !(&valid_q[NumStages-1:k]);
    end
  endgenerate

  assign in_stall_o = !en[0];

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < NumStages; i++) begin
      valid_d[i] = en[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Restore the sign of the quotient, add to the phase and clamp
  always_comb begin
    u1_quo_w   = {{(ShiftW-QuoW){1'b0}}, quo_i};
    u1_shift_w = neg_i ? (~u1_quo_w + 1'b1) : u1_quo_w;
    u1_sum_w   = $signed({{(NewPhW-PhaseW){1'b0}}, side_i.phase})
               + $signed({{(NewPhW-ShiftW){u1_shift_w[ShiftW-1]}}, u1_shift_w});
    u1_np_d    = u1_sum_w;
    u1_act_d   = ActNone;
    if (side_i.hit) begin
      if (side_i.positive) begin
        u1_act_d = ActEarlier;
        if (u1_sum_w > NpOne) begin
          u1_np_d = NpOne;
        end
      end else begin
        u1_act_d = ActLater;
        if (u1_sum_w < 0) begin
          u1_np_d = '0;
        end
      end
    end
  end

  // New firing time = 1 + now - shifted phase, or the old one if untouched
  always_comb begin
    u2_npx_w  = {{(TimeBits-NewPhW){u1_np_q[NewPhW-1]}}, u1_np_q};
    u2_time_w = u1_nowp_q - u2_npx_w;
    out_word_d.action        = u1_act_q;
    out_word_d.new_fire_time = (u1_act_q == ActNone) ? u1_fire_q : u2_time_w;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u1_np_q   <= u1_np_d;
      u1_act_q  <= u1_act_d;
      u1_nowp_q <= side_i.now_time + OneTime;
      u1_fire_q <= side_i.fire_time;
    end
    if (en[1]) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

// ===== rtl/trapezoid_phase_response_update_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 5 numerator stages, 18 divider stages at one quotient bit each,
// 2 update stages.
// Throughput: one word per cycle while the output is not stalled; stages refill
// around a stalled output, and the divider bit pipeline sets the depth.
// Reset: configuration registers take their defaults (a=0, b=0.25, c=0.75,
// d=1.0, heights 0) and the pipeline empties.
// ----------------------------------------------------------------------------
// trapezoid_phase_response_update_top: pulse-coupled oscillator phase update
// Forms the oscillator phase on each pulse, applies a trapezoidal phase
// response and returns the rescheduled firing time with an action code.
// ----------------------------------------------------------------------------
module trapezoid_phase_response_update_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tpru_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tpru_pkg::out_word_t             out_word_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpru_pkg::ApbAddrW-1:0]   paddr,
  input  logic [tpru_pkg::ApbDataW-1:0]   pwdata,
  output logic [tpru_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);
  import tpru_pkg::*;

  localparam int unsigned SideW = $bits(side_t);

  cfg_t            cfg_q;
  logic            wr_en;
  logic [2:0]      reg_sel;

  logic            nd_valid, nd_stall, nd_neg;
  logic [NumW-1:0] nd_num;
  logic [DenW-1:0] nd_den;
  side_t           nd_side;

  logic            du_valid, du_stall, du_neg;
  logic [QuoW-1:0] du_quo;
  side_t           du_side;

  // Register bus: zero wait states
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[ApbAddrW-1:2];

  // Write configuration, masked to register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.point_a    <= PointAReset;
      cfg_q.point_b    <= PointBReset;
      cfg_q.point_c    <= PointCReset;
      cfg_q.point_d    <= PointDReset;
      cfg_q.height_one <= HeightReset;
      cfg_q.height_two <= HeightReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegPointA:    cfg_q.point_a    <= pwdata[PointW-1:0];
        RegPointB:    cfg_q.point_b    <= pwdata[PointW-1:0];
        RegPointC:    cfg_q.point_c    <= pwdata[PointW-1:0];
        RegPointD:    cfg_q.point_d    <= pwdata[PointW-1:0];
        RegHeightOne: cfg_q.height_one <= pwdata[HeightW-1:0];
        RegHeightTwo: cfg_q.height_two <= pwdata[HeightW-1:0];
        default: ;
      endcase
    end
  end

  // Read back raw register bits
  always_comb begin
    unique case (reg_sel)
      RegPointA:    prdata = ApbDataW'(cfg_q.point_a);
      RegPointB:    prdata = ApbDataW'(cfg_q.point_b);
      RegPointC:    prdata = ApbDataW'(cfg_q.point_c);
      RegPointD:    prdata = ApbDataW'(cfg_q.point_d);
      RegHeightOne: prdata = ApbDataW'(cfg_q.height_one);
      RegHeightTwo: prdata = ApbDataW'(cfg_q.height_two);
      default:      prdata = '0;
    endcase
  end

  tpru_numer u_numer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cfg_i       (cfg_q),
    .out_valid_o (nd_valid),
    .out_stall_i (nd_stall),
    .num_o       (nd_num),
    .den_o       (nd_den),
    .neg_o       (nd_neg),
    .side_o      (nd_side)
  );

  tpru_div #(
    .NumW  (NumW),
    .DenW  (DenW),
    .QuoW  (QuoW),
    .SideW (SideW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (nd_valid),
    .in_stall_o  (nd_stall),
    .num_i       (nd_num),
    .den_i       (nd_den),
    .neg_i       (nd_neg),
    .side_i      (nd_side),
    .out_valid_o (du_valid),
    .out_stall_i (du_stall),
    .quo_o       (du_quo),
    .neg_o       (du_neg),
    .side_o      (du_side)
  );

  tpru_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (du_valid),
    .in_stall_o  (du_stall),
    .quo_i       (du_quo),
    .neg_i       (du_neg),
    .side_i      (du_side),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

// ===== verif/trapezoid_phase_response_update_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_phase_response_update_top_tb: self-checking bench of the phase update
// Drives pulse words under random idling on both channels and programs the
// trapezoid over the register port between runs. Each result word is checked
// against its typed table row or an in-bench phase response calculation. A short
// table of corner pulses comes first, then random pulses under varied trapezoids.
// ----------------------------------------------------------------------------
module trapezoid_phase_response_update_top_tb;
  import tpru_pkg::*;

  localparam longint      OneQ       = longint'(1) << FracBits;
  localparam logic [31:0] PointMask  = (32'd1 << PointW) - 32'd1;
  localparam logic [31:0] HeightMask = (32'd1 << HeightW) - 32'd1;
  localparam int          DirRows    = 26;
  localparam int          RunWords   = 150;

  // One table row: trapezoid shape index, pulse word, and an optional typed result
  typedef struct packed {
    logic [1:0] setting;
    in_word_t   word;
    logic       typed;
    out_word_t  want;
  } pulse_row_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_word_t            in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_word_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ApbAddrW-1:0] paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  cfg_t        trap_cfg;
  out_word_t   fire_expect_q [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  pulse_row_t  pulse_table [DirRows];
  cfg_t        dir_setting [4];

  trapezoid_phase_response_update_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("trapezoid_phase_response_update_top regression: fail");
    $finish;
  end

  task automatic log_mismatch(string what);
    $display("[%0t] MISMATCH %s", $realtime, what);
    mismatch_count++;
  endtask

  // Compute the rescheduled firing time of one pulse under a trapezoid shape
  function automatic out_word_t predict_fire(in_word_t w, cfg_t cf);
    longint              pa, pb, pc, pd, h1, h2, phase, shift, np;
    logic [TimeBits-1:0] gap;
    out_word_t           r;
    r.new_fire_time = w.scheduled_fire_time;
    r.action        = ActNone;
    pa = longint'(cf.point_a);
    pb = longint'(cf.point_b);
    pc = longint'(cf.point_c);
    pd = longint'(cf.point_d);
    h1 = longint'(signed'(cf.height_one));
    h2 = longint'(signed'(cf.height_two));
    // Form the phase; out of the window unless it lies in [0, 2)
    if (w.now_time >= w.scheduled_fire_time) begin
      gap = w.now_time - w.scheduled_fire_time;
      if (gap >= OneTime) return r;
      phase = OneQ + longint'(gap);
    end else begin
      gap = w.scheduled_fire_time - w.now_time;
      if (gap > OneTime) return r;
      phase = OneQ - longint'(gap);
    end
    // Pick the segment; each one divides once, truncating toward zero
    if (phase < pa) return r;
    else if (phase < pb) shift = ((phase - pa) * h1) / (pb - pa);
    else if (phase < pc) shift = ((phase - pb) * h2 + (pc - phase) * h1) / (pc - pb);
    else if (phase < pd) shift = ((pd - phase) * h2) / (pd - pc);
    else return r;
    // Clamp on the coupling side only
    np = phase + shift;
    if (w.coupling_positive) begin
      if (np > OneQ) np = OneQ;
      r.action = ActEarlier;
    end else begin
      if (np < 0) np = 0;
      r.action = ActLater;
    end
    r.new_fire_time = TimeBits'(longint'(w.now_time) + OneQ - np);
    return r;
  endfunction

  function automatic pulse_row_t pulse_row(logic [1:0] setting, logic [TimeBits-1:0] now,
                                           logic [TimeBits-1:0] fire, logic pos,
                                           logic typed, action_e act);
    pulse_row_t row;
    row.setting                       = setting;
    row.word.now_time                 = now;
    row.word.scheduled_fire_time      = fire;
    row.word.coupling_positive        = pos;
    row.typed                         = typed;
    row.want.new_fire_time            = fire;
    row.want.action                   = act;
    return row;
  endfunction

  // Build a trapezoid shape for one random run
  function automatic cfg_t random_setting(int unsigned k);
    cfg_t        s;
    int unsigned p [$];
    int unsigned base;
    base = $urandom_range(32'h0E000);
    for (int i = 0; i < 4; i++) begin
      if (k == 2) p.push_back(base + $urandom_range(32'h02000));
      else p.push_back($urandom_range(32'h10000));
    end
    if (k != 3) p.sort();
    s.point_a    = PointW'(p[0]);
    s.point_b    = PointW'(p[1]);
    s.point_c    = PointW'(p[2]);
    s.point_d    = PointW'(p[3]);
    s.height_one = HeightW'($urandom_range(32'h20000) - 32'h10000);
    s.height_two = HeightW'($urandom_range(32'h20000) - 32'h10000);
    case (k)
      0: s = '{17'h00000, 17'h00000, 17'h10000, 17'h10000, 18'h10000, 18'h30000};
      4: s = '{PointW'($urandom), PointW'($urandom), PointW'($urandom), PointW'($urandom),
               HeightW'($urandom), HeightW'($urandom)};
      5: s = '{17'h00000, 17'h10000, 17'h10000, 17'h10000, 18'h30000, 18'h10000};
      default: ;
    endcase
    return s;
  endfunction

  // Draw a pulse, mostly with its phase near or inside the window
  function automatic in_word_t random_pulse(cfg_t cf);
    in_word_t    w;
    logic [63:0] raw;
    int          phase;
    int unsigned pick;
    raw        = {$urandom, $urandom};
    w.now_time = raw[TimeBits-1:0];
    pick       = $urandom_range(99);
    if (pick < 60) begin
      phase = $urandom_range(32'h10000);
    end else if (pick < 85) begin
      case ($urandom_range(3))
        0: phase = int'(cf.point_a);
        1: phase = int'(cf.point_b);
        2: phase = int'(cf.point_c);
        default: phase = int'(cf.point_d);
      endcase
      phase = phase + int'($urandom_range(2)) - 1;
    end else begin
      phase = int'($urandom_range(32'h20200)) - 32'h100;
    end
    w.scheduled_fire_time = TimeBits'(w.now_time + OneTime - TimeBits'(phase));
    if (pick >= 90) begin
      raw = {$urandom, $urandom};
      w.scheduled_fire_time = raw[TimeBits-1:0];
    end
    w.coupling_positive = 1'($urandom_range(1));
    return w;
  endfunction

  // Write every register with junk above its width, then read it back
  task automatic apply_setting(cfg_t s);
    reg_e        r;
    logic [31:0] val;
    logic [31:0] mask;
    r = r.first();
    do begin
      case (r)
        RegPointA:    val = 32'(s.point_a);
        RegPointB:    val = 32'(s.point_b);
        RegPointC:    val = 32'(s.point_c);
        RegPointD:    val = 32'(s.point_d);
        RegHeightOne: val = 32'(s.height_one);
        RegHeightTwo: val = 32'(s.height_two);
        default:      val = '0;
      endcase
      mask = (r inside {RegHeightOne, RegHeightTwo}) ? HeightMask : PointMask;
      // setup and access of the write
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ApbAddrW'(4 * r);
      pwdata  <= (val & mask) | ($urandom & ~mask);
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      case (r)
        RegPointA:    trap_cfg.point_a    = val[PointW-1:0];
        RegPointB:    trap_cfg.point_b    = val[PointW-1:0];
        RegPointC:    trap_cfg.point_c    = val[PointW-1:0];
        RegPointD:    trap_cfg.point_d    = val[PointW-1:0];
        RegHeightOne: trap_cfg.height_one = val[HeightW-1:0];
        RegHeightTwo: trap_cfg.height_two = val[HeightW-1:0];
        default: ;
      endcase
      // read back the same register
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if ((prdata & mask) != (val & mask))
        log_mismatch($sformatf("register %s reads %h, want %h", r.name(), prdata & mask,
                               val & mask));
      r = r.next();
    end while (r != r.first());
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one word, idling first at the sender's rate, and log its result on accept
  task automatic send_pulse(in_word_t w, logic typed, out_word_t want);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    fire_expect_q.push_back(typed ? want : predict_fire(w, trap_cfg));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (fire_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Stall the result channel at the current rate
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check each accepted result word against the oldest expectation
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fire_expect_q.size() == 0) begin
        log_mismatch($sformatf("result %h/%0d with nothing expected",
                               out_word_o.new_fire_time, out_word_o.action));
      end else begin
        want = fire_expect_q.pop_front();
        if (out_word_o.new_fire_time !== want.new_fire_time)
          log_mismatch($sformatf("new_fire_time %h, want %h",
                                 out_word_o.new_fire_time, want.new_fire_time));
        if (out_word_o.action !== want.action)
          log_mismatch($sformatf("action %0d, want %0d", out_word_o.action, want.action));
      end
    end
  end

  initial begin
    logic [1:0] cur_setting;
    // shapes used by the directed table: reset, steep full-height, unordered, dip
    dir_setting[0] = '{PointAReset, PointBReset, PointCReset, PointDReset,
                       HeightReset, HeightReset};
    dir_setting[1] = '{17'h00000, 17'h04000, 17'h0C000, 17'h10000, 18'h10000, 18'h30000};
    dir_setting[2] = '{17'h08000, 17'h04000, 17'h0A000, 17'h0C000, 18'h38000, 18'h06000};
    dir_setting[3] = '{17'h00000, 17'h01000, 17'h02000, 17'h10000, 18'h30000, 18'h3CCCD};

    // reset shape: zero heights leave the firing time alone inside the window
    pulse_table[0]  = pulse_row(0, 48'h0001_0000_0000, 48'h0001_0001_0001, 1, 1, ActNone);
    pulse_table[1]  = pulse_row(0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 1, ActNone);
    pulse_table[2]  = pulse_row(0, 48'h0000_0001_0000, 48'h0, 1, 1, ActNone);
    pulse_table[3]  = pulse_row(0, 48'h0, 48'h0000_0001_0000, 1, 1, ActEarlier);
    pulse_table[4]  = pulse_row(0, 48'h0, 48'h0000_0001_0000, 0, 1, ActLater);
    pulse_table[5]  = pulse_row(0, 48'hFFFF_FFFF_0000, 48'hFFFF_FFFF_8000, 0, 1, ActLater);
    pulse_table[6]  = pulse_row(0, 48'h1234_5678_9ABC, 48'h1234_5678_9ABD, 1, 1, ActEarlier);
    pulse_table[7]  = pulse_row(0, 48'h0, 48'h0, 1, 1, ActNone);
    pulse_table[8]  = pulse_row(0, 48'hFFFF_FFFF_FFFF, 48'h0, 1, 1, ActNone);
    pulse_table[9]  = pulse_row(0, 48'h0, 48'hFFFF_FFFF_FFFF, 0, 1, ActNone);
    // full heights: clamp at one, wrap below zero and past the top of time
    pulse_table[10] = pulse_row(1, 48'h0, 48'h0E000, 1, 0, ActNone);
    pulse_table[11] = pulse_row(1, 48'h0, 48'h0E000, 0, 0, ActNone);
    pulse_table[12] = pulse_row(1, 48'h0, 48'h0C000, 1, 0, ActNone);
    pulse_table[13] = pulse_row(1, 48'h0, 48'h0C000, 0, 0, ActNone);
    pulse_table[14] = pulse_row(1, 48'h5_0000, 48'h5_8000, 1, 0, ActNone);
    pulse_table[15] = pulse_row(1, 48'hFFFF_FFFF_DFFF, 48'hFFFF_FFFF_FFFF, 0, 0, ActNone);
    pulse_table[16] = pulse_row(1, 48'h100, 48'h4101, 0, 0, ActNone);
    pulse_table[17] = pulse_row(1, 48'h10, 48'h100F, 1, 0, ActNone);
    // unordered points: empty rise, then the middle and fall segments
    pulse_table[18] = pulse_row(2, 48'h0, 48'h0A000, 1, 0, ActNone);
    pulse_table[19] = pulse_row(2, 48'h0, 48'h07000, 1, 0, ActNone);
    pulse_table[20] = pulse_row(2, 48'h0, 48'h07000, 0, 0, ActNone);
    pulse_table[21] = pulse_row(2, 48'h0, 48'h05000, 0, 0, ActNone);
    pulse_table[22] = pulse_row(2, 48'h0, 48'h04000, 1, 0, ActNone);
    // steep dip: shifted phase below zero on both couplings
    pulse_table[23] = pulse_row(3, 48'h2_0000, 48'h2_F800, 1, 0, ActNone);
    pulse_table[24] = pulse_row(3, 48'h2_0000, 48'h2_E800, 0, 0, ActNone);
    pulse_table[25] = pulse_row(3, 48'h2_0000, 48'h2_8889, 1, 0, ActNone);

    trap_cfg       = dir_setting[0];
    send_idle_pct  = 32;
    recv_stall_pct = 85;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table, reshaping the trapezoid when the row asks
    cur_setting = 2'd0;
    for (int i = 0; i < DirRows; i++) begin
      if (pulse_table[i].setting != cur_setting) begin
        drain_results();
        cur_setting = pulse_table[i].setting;
        apply_setting(dir_setting[cur_setting]);
      end
      send_pulse(pulse_table[i].word, pulse_table[i].typed, pulse_table[i].want);
    end

    // Random runs, two per idling pattern
    for (int unsigned k = 0; k < 6; k++) begin
      drain_results();
      apply_setting(random_setting(k));
      case (k / 2)
        0: begin
          send_idle_pct  = 32;
          recv_stall_pct = 85;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 32;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (RunWords) send_pulse(random_pulse(trap_cfg), 1'b0, '0);
    end

    // Wait out the pipeline so late or extra words show up
    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("trapezoid_phase_response_update_top regression: pass");
    end else begin
      $display("trapezoid_phase_response_update_top regression: fail");
    end
    $finish;
  end

endmodule
